// ===== rtl/ps2md_pkg.sv =====
`default_nettype none
package ps2md_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DeltaW = 11;
  localparam int unsigned GainW  = 3;

  // Register indexes on the configuration port
  localparam logic [1:0] RegFormat    = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegGain      = 2'd2;

  // Header byte bit positions
  localparam int unsigned HdrLeft   = 0;
  localparam int unsigned HdrRight  = 1;
  localparam int unsigned HdrMiddle = 2;
  localparam int unsigned HdrSignX  = 4;
  localparam int unsigned HdrSignY  = 5;
  localparam int unsigned HdrOvfX   = 6;
  localparam int unsigned HdrOvfY   = 7;

  localparam logic [GainW-1:0] GainMin = 3'd1;
  localparam logic [GainW-1:0] GainMax = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] threshold;
    logic [GainW-1:0] gain;
    logic             wheel_fmt;
  } cfg_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     btn_middle;
    logic                     btn_right;
    logic                     btn_left;
  } pkt_t;

endpackage
`default_nettype wire

// ===== rtl/ps2md_front.sv =====
`default_nettype none
module ps2md_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ps2md_pkg::cfg_t     cfg_i,
  input  wire                 byte_valid_i,
  output logic                byte_ready_o,
  input  wire  [7:0]          byte_i,
  output logic                push_o,
  output ps2md_pkg::pkt_t     pkt_o,
  input  wire                 full_i
);
  import ps2md_pkg::*;

  logic [1:0]       pos_q, pos_d;
  logic [ByteW-1:0] hdr_q, x_q, y_q;
  logic [1:0]       last_pos;
  logic             take, complete, drop;
  logic [ByteW-1:0] y_cur;
  logic signed [8:0]  dx9, dy9;
  logic [8:0]       abs_x, abs_y;
  logic [GainW-1:0] gain;
  logic             accel;
  logic signed [12:0] mul_x, mul_y;

  assign byte_ready_o = !full_i;
  assign take         = byte_valid_i && byte_ready_o;
  assign last_pos     = cfg_i.wheel_fmt ? 2'd3 : 2'd2;
  assign complete     = (pos_q >= last_pos);
  assign pos_d        = complete ? 2'd0 : pos_q + 2'd1;

  // The Y byte may be arriving right now in the short format
  assign y_cur = (pos_q == 2'd2) ? byte_i : y_q;

  assign drop = !cfg_i.wheel_fmt && (hdr_q[HdrOvfX] || hdr_q[HdrOvfY]);

  assign dx9 = $signed({hdr_q[HdrSignX], x_q});
  assign dy9 = $signed({hdr_q[HdrSignY], y_cur});

  assign abs_x = dx9[8] ? 9'(-dx9) : 9'(dx9);
  assign abs_y = dy9[8] ? 9'(-dy9) : 9'(dy9);
  assign accel = (abs_x > {1'b0, cfg_i.threshold}) || (abs_y > {1'b0, cfg_i.threshold});

  always_comb begin
    gain = cfg_i.gain;
    if (cfg_i.gain < GainMin) gain = GainMin;
    else if (cfg_i.gain > GainMax) gain = GainMax;
    if (!accel) gain = GainMin;
  end

  assign mul_x = dx9 * $signed({1'b0, gain});
  assign mul_y = dy9 * $signed({1'b0, gain});

  assign push_o           = take && complete && !drop;
  assign pkt_o.dx         = mul_x[DeltaW-1:0];
  assign pkt_o.dy         = mul_y[DeltaW-1:0];
  assign pkt_o.btn_left   = hdr_q[HdrLeft];
  assign pkt_o.btn_right  = hdr_q[HdrRight];
  assign pkt_o.btn_middle = hdr_q[HdrMiddle];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      hdr_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else if (take) begin
      pos_q <= pos_d;
      if (pos_q == 2'd0) hdr_q <= byte_i;
      if (pos_q == 2'd1) x_q   <= byte_i;
      if (pos_q == 2'd2) y_q   <= byte_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2md_fifo.sv =====
`default_nettype none
module ps2md_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  ps2md_pkg::pkt_t     pkt_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output ps2md_pkg::pkt_t     pkt_o
);
  import ps2md_pkg::*;

  pkt_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign pkt_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pkt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2md_back.sv =====
`default_nettype none
module ps2md_back #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  ps2md_pkg::pkt_t     pkt_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [15:0]         pos_x_o,
  output logic [15:0]         pos_y_o,
  output ps2md_pkg::pkt_t     pkt_o
);
  import ps2md_pkg::*;

  localparam int unsigned SW = ((POS_WIDTH > DeltaW) ? POS_WIDTH : DeltaW) + 1;
  localparam int unsigned OW = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 1;
  localparam logic signed [SW-1:0] PMax = {{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] PMin = ~PMax;

  logic signed [POS_WIDTH-1:0] cur_x_q, cur_y_q, new_x, new_y;
  logic signed [SW-1:0]        sum_x, sum_y;
  logic [OW-1:0]               ext_x, ext_y;
  logic                        valid_q;
  logic [15:0]                 px_q, py_q;
  pkt_t                        pkt_q;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  assign sum_x = $signed({{(SW-POS_WIDTH){cur_x_q[POS_WIDTH-1]}}, cur_x_q})
               + $signed({{(SW-DeltaW){pkt_i.dx[DeltaW-1]}}, pkt_i.dx});
  assign sum_y = $signed({{(SW-POS_WIDTH){cur_y_q[POS_WIDTH-1]}}, cur_y_q})
               - $signed({{(SW-DeltaW){pkt_i.dy[DeltaW-1]}}, pkt_i.dy});

  // Clamp to the signed position range
  always_comb begin
    if (sum_x > PMax)      new_x = PMax[POS_WIDTH-1:0];
    else if (sum_x < PMin) new_x = PMin[POS_WIDTH-1:0];
    else                   new_x = sum_x[POS_WIDTH-1:0];
    if (sum_y > PMax)      new_y = PMax[POS_WIDTH-1:0];
    else if (sum_y < PMin) new_y = PMin[POS_WIDTH-1:0];
    else                   new_y = sum_y[POS_WIDTH-1:0];
  end

  assign ext_x = {{(OW-POS_WIDTH){new_x[POS_WIDTH-1]}}, new_x};
  assign ext_y = {{(OW-POS_WIDTH){new_y[POS_WIDTH-1]}}, new_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        cur_x_q <= new_x;
        cur_y_q <= new_y;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      px_q  <= ext_x[15:0];
      py_q  <= ext_y[15:0];
      pkt_q <= pkt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign pkt_o       = pkt_q;

endmodule
`default_nettype wire

// ===== rtl/ps2md_packet_decoder_core.sv =====
// PS/2 mouse packet decoder.
// Raw mouse bytes enter on the s_axis channel, one byte per beat in tdata.
// Bytes are framed into 3-byte packets, or 4-byte wheel packets when
// packet_format is set (the fourth byte is discarded). Each finished packet
// yields one beat on m_axis with the new saturated pointer position, the
// three buttons and the accelerated deltas. In the 3-byte format a packet
// whose header carries an overflow bit is dropped and yields no beat.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i:
// index 0 packet_format, 1 accel_threshold, 2 accel_gain. Write them only
// while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The front
// framer decodes and scales a packet in the cycle its final byte is taken
// and pushes it into a two-entry queue; the back end pops one packet per
// cycle while the output register is free or m_axis_tready is high, adds
// it to the position accumulator and holds it in the output register.
// When m_axis_tready is low the output beat holds, the queue fills, and
// s_axis_tready drops once both queue entries are taken.
// Reset clears the framer, the position (0, 0) and the queue, and loads
// packet_format 0, accel_threshold 5 and accel_gain 2.
`default_nettype none
module ps2_mouse_packet_decoder_core #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [32] button_left, [33] button_right,
  // [34] button_middle, [45:35] delta_x, [56:46] delta_y, [63:57] zero
  output logic [63:0] m_axis_tdata
);
  import ps2md_pkg::*;

  cfg_t        cfg_q;
  logic        push, full, pop, empty;
  pkt_t        front_pkt, head_pkt, out_pkt;
  logic [15:0] pos_x, pos_y;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_fmt <= 1'b0;
      cfg_q.threshold <= 8'd5;
      cfg_q.gain      <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegFormat:    cfg_q.wheel_fmt <= cfg_data_i[0];
        RegThreshold: cfg_q.threshold <= cfg_data_i;
        RegGain:      cfg_q.gain      <= cfg_data_i[GainW-1:0];
        default:      ;
      endcase
    end
  end

  ps2md_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .pkt_o        (front_pkt),
    .full_i       (full)
  );

  ps2md_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (front_pkt),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .pkt_o   (head_pkt)
  );

  ps2md_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pkt_i       (head_pkt),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pkt_o       (out_pkt)
  );

  // Pack the beat: last field in the top bits, pad with zeros to 64 bits
  assign m_axis_tdata = {7'd0, out_pkt.dy, out_pkt.dx, out_pkt.btn_middle,
                         out_pkt.btn_right, out_pkt.btn_left, pos_y, pos_x};

endmodule
`default_nettype wire
